// ===== rtl/irpd_pkg.sv =====
// ---------------------------------------------------------------------------
// irpd_pkg
// Types, register map and reset values shared by the IR pulse-distance
// command decoder and its symbol slicer.
// ---------------------------------------------------------------------------
package irpd_pkg;

	localparam int DUR_W   = 15;
	localparam int SUM_W   = DUR_W + 1;
	localparam int BAND_W  = 16;
	localparam int WIN_W   = 7;
	localparam int CMD_W   = 8;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	localparam logic [BAND_W-1:0] ZERO_LOW_RST  = 16'd1050;
	localparam logic [BAND_W-1:0] ZERO_HIGH_RST = 16'd1250;
	localparam logic [BAND_W-1:0] ONE_LOW_RST   = 16'd2100;
	localparam logic [BAND_W-1:0] ONE_HIGH_RST  = 16'd2400;
	localparam logic [WIN_W-1:0]  WIN_FIRST_RST = 7'd17;
	localparam logic [WIN_W-1:0]  WIN_STOP_RST  = 7'd25;

	// word index of each register (byte address 4*index)
	typedef enum logic [2:0] {
		REG_ZERO_LOW   = 3'd0,
		REG_ZERO_HIGH  = 3'd1,
		REG_ONE_LOW    = 3'd2,
		REG_ONE_HIGH   = 3'd3,
		REG_WIN_FIRST  = 3'd4,
		REG_WIN_STOP   = 3'd5,
		REG_SIRC_SHIFT = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [BAND_W-1:0] zero_low;
		logic [BAND_W-1:0] zero_high;
		logic [BAND_W-1:0] one_low;
		logic [BAND_W-1:0] one_high;
	} band_cfg_t;

	// outcome of one symbol: shift a bit in or leave the register alone
	typedef struct packed {
		logic shift_en;
		logic bit_val;
	} sym_class_t;

endpackage

// ===== rtl/irpd_slicer.sv =====
// ---------------------------------------------------------------------------
// irpd_slicer
// Adds the two level durations of a symbol and classifies the period
// against the zero and one bands.
// ---------------------------------------------------------------------------
module irpd_slicer
	import irpd_pkg::*;
(
	input  logic [DUR_W-1:0] first_duration,
	input  logic [DUR_W-1:0] second_duration,
	input  logic             in_window,
	input  band_cfg_t        bands,
	output sym_class_t       cls
);

	logic [SUM_W-1:0] period;
	logic             is_zero;
	logic             is_one;

	// two 15-bit durations always fit in 16 bits
	assign period  = {1'b0, first_duration} + {1'b0, second_duration};
	assign is_zero = (period > bands.zero_low) && (period < bands.zero_high);
	assign is_one  = (period > bands.one_low) && (period < bands.one_high);

	// zero band wins where the bands overlap
	always_comb begin
		cls.shift_en = in_window && (is_zero || is_one);
		cls.bit_val  = !is_zero;
	end

endmodule

// ===== rtl/ir_pulse_distance_command_decoder_unit.sv =====
// ---------------------------------------------------------------------------
// ir_pulse_distance_command_decoder_unit
// Pulse-distance IR command decoder: gathers one byte per frame from the
// symbol periods inside a configurable index window.
// ---------------------------------------------------------------------------
// Takes one symbol per clock. A symbol is held in the input
// register, where its period is classified and the shift register and
// symbol counter update; on the last symbol of a frame the byte lands in
// the output register as that symbol leaves the input register. While that byte waits
// for out_ready, a following frame-end symbol holds in the input register;
// other symbols keep flowing at one per cycle. Configure through the APB
// port only while no symbol is in flight.
module ir_pulse_distance_command_decoder_unit
	import irpd_pkg::*;
#(
	parameter int MAX_SYMBOLS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [DUR_W-1:0]  first_duration,
	input  logic [DUR_W-1:0]  second_duration,
	input  logic              frame_end,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CMD_W-1:0]  command_byte
);

	localparam int IDX_W = $clog2(MAX_SYMBOLS + 1);
	localparam int CMP_W = (IDX_W > WIN_W) ? IDX_W : WIN_W;

	band_cfg_t        bands_q;
	logic [WIN_W-1:0] win_first_q;
	logic [WIN_W-1:0] win_stop_q;
	logic             sirc_q;

	logic             valid_s1;
	logic [DUR_W-1:0] first_s1;
	logic [DUR_W-1:0] second_s1;
	logic             last_s1;

	logic [IDX_W-1:0] idx_q;
	logic [CMD_W-1:0] gather_q;
	logic             out_valid_q;
	logic [CMD_W-1:0] cmd_q;

	logic             cfg_wr;
	reg_idx_t         reg_sel;
	logic             s1_adv;
	logic             below_max;
	logic [CMP_W-1:0] idx_ext;
	logic             in_window;
	sym_class_t       cls;
	logic [CMD_W-1:0] gather_next;
	logic [IDX_W-1:0] idx_next;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bands_q.zero_low  <= ZERO_LOW_RST;
			bands_q.zero_high <= ZERO_HIGH_RST;
			bands_q.one_low   <= ONE_LOW_RST;
			bands_q.one_high  <= ONE_HIGH_RST;
			win_first_q       <= WIN_FIRST_RST;
			win_stop_q        <= WIN_STOP_RST;
			sirc_q            <= 1'b0;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_ZERO_LOW:   bands_q.zero_low  <= pwdata[BAND_W-1:0];
				REG_ZERO_HIGH:  bands_q.zero_high <= pwdata[BAND_W-1:0];
				REG_ONE_LOW:    bands_q.one_low   <= pwdata[BAND_W-1:0];
				REG_ONE_HIGH:   bands_q.one_high  <= pwdata[BAND_W-1:0];
				REG_WIN_FIRST:  win_first_q       <= pwdata[WIN_W-1:0];
				REG_WIN_STOP:   win_stop_q        <= pwdata[WIN_W-1:0];
				REG_SIRC_SHIFT: sirc_q            <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_ZERO_LOW:   prdata = DATA_W'(bands_q.zero_low);
			REG_ZERO_HIGH:  prdata = DATA_W'(bands_q.zero_high);
			REG_ONE_LOW:    prdata = DATA_W'(bands_q.one_low);
			REG_ONE_HIGH:   prdata = DATA_W'(bands_q.one_high);
			REG_WIN_FIRST:  prdata = DATA_W'(win_first_q);
			REG_WIN_STOP:   prdata = DATA_W'(win_stop_q);
			REG_SIRC_SHIFT: prdata = DATA_W'(sirc_q);
			default:        prdata = '0;
		endcase
	end

	// input register; a frame-end symbol waits while the output is full
	assign s1_adv   = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			first_s1  <= first_duration;
			second_s1 <= second_duration;
			last_s1   <= frame_end;
		end
	end

	// window test; the saturated index is never decoded
	assign below_max = idx_q < IDX_W'(MAX_SYMBOLS);
	assign idx_ext   = CMP_W'(idx_q);
	assign in_window = below_max && (idx_ext >= CMP_W'(win_first_q))
	                   && (idx_ext < CMP_W'(win_stop_q));

	irpd_slicer u_slicer (
		.first_duration  (first_s1),
		.second_duration (second_s1),
		.in_window       (in_window),
		.bands           (bands_q),
		.cls             (cls)
	);

	assign gather_next = cls.shift_en ? {cls.bit_val, gather_q[CMD_W-1:1]} : gather_q;
	assign idx_next    = below_max ? idx_q + IDX_W'(1) : idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			gather_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_adv) begin
				if (last_s1) begin
					idx_q    <= '0;
					gather_q <= '0;
				end else begin
					idx_q    <= idx_next;
					gather_q <= gather_next;
				end
			end
			if (s1_adv && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// SIRC mode drops one more bit at frame end
	always_ff @(posedge clk) begin
		if (s1_adv && last_s1) begin
			cmd_q <= sirc_q ? {1'b0, gather_next[CMD_W-1:1]} : gather_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign command_byte = cmd_q;

`ifndef SYNTHESIS
	a_idx_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_W'(MAX_SYMBOLS))
		else $error("symbol index ran past its saturation value");

	a_frame_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && last_s1) |=> (idx_q == '0) && (gather_q == '0))
		else $error("state not cleared after frame end");

	a_frame_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && last_s1) |=> out_valid_q)
		else $error("frame end transfer produced no result");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && last_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a waiting result");

	a_idx_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && !last_s1 && below_max) |=> (idx_q == $past(idx_q) + IDX_W'(1)))
		else $error("symbol index did not advance");
`endif

endmodule

// ===== tb/ir_pulse_distance_command_decoder_unit_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ir_pulse_distance_command_decoder_unit_tb
// Self-checking bench for the IR pulse-distance command decoder. The bench
// drives IR symbols over a valid/ready input with bursty gaps and programs
// the band and window registers over APB. A local decoder model predicts
// each command byte, and every output transfer is checked against it in
// order. The downstream ready stalls on its own random pattern.
// ---------------------------------------------------------------------------
module ir_pulse_distance_command_decoder_unit_tb;
	import irpd_pkg::*;

	localparam int NUM_ITEMS     = 2000;
	localparam int NUM_PHASES    = 8;
	localparam int MAX_SYM       = 64;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES   = 300;
	localparam int SUM_MAX       = 65534;
	localparam int DUR_MAX       = 32767;

	typedef enum int {
		RX_ALWAYS,
		RX_HALF,
		RX_SLOW,
		RX_TOGGLE
	} rx_mode_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [DUR_W-1:0]  first_duration = '0;
	logic [DUR_W-1:0]  second_duration = '0;
	logic              frame_end = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [CMD_W-1:0]  command_byte;

	// copy of the register file as the decoder should hold it
	logic [BAND_W-1:0] zero_low_q   = ZERO_LOW_RST;
	logic [BAND_W-1:0] zero_high_q  = ZERO_HIGH_RST;
	logic [BAND_W-1:0] one_low_q    = ONE_LOW_RST;
	logic [BAND_W-1:0] one_high_q   = ONE_HIGH_RST;
	logic [WIN_W-1:0]  win_first_q  = WIN_FIRST_RST;
	logic [WIN_W-1:0]  win_stop_q   = WIN_STOP_RST;
	logic              sirc_shift_q = 1'b0;

	// decoder state
	int               sym_idx = 0;
	logic [CMD_W-1:0] gather = '0;

	logic [CMD_W-1:0] cmd_expected_q[$];
	logic [CMD_W-1:0] cmd_head;

	int       mismatch_cnt = 0;
	int       items_sent = 0;
	int       cycle_cnt = 0;
	int       burst_left = 0;
	bit       gaps_on = 1'b1;
	bit       hold_req = 1'b0;
	int       hold_cnt = 0;
	rx_mode_t rx_mode = RX_ALWAYS;
	int       rx_mode_left = 0;

	ir_pulse_distance_command_decoder_unit #(
		.MAX_SYMBOLS(MAX_SYM)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.first_duration (first_duration),
		.second_duration(second_duration),
		.frame_end      (frame_end),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.command_byte   (command_byte)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// advance the command decoder by one symbol, queue the byte on frame end
	function automatic void decode_symbol(logic [DUR_W-1:0] d0, logic [DUR_W-1:0] d1,
			logic last);
		logic [SUM_W-1:0] sum;
		logic [CMD_W-1:0] cmd;
		sum = SUM_W'(d0) + SUM_W'(d1);
		if (sym_idx < MAX_SYM && sym_idx >= win_first_q && sym_idx < win_stop_q) begin
			if (sum > zero_low_q && sum < zero_high_q)
				gather = gather >> 1;
			else if (sum > one_low_q && sum < one_high_q)
				gather = {1'b1, gather[CMD_W-1:1]};
		end
		if (sym_idx < MAX_SYM)
			sym_idx++;
		if (last) begin
			cmd = sirc_shift_q ? (gather >> 1) : gather;
			cmd_expected_q.push_back(cmd);
			sym_idx = 0;
			gather = '0;
		end
	endfunction

	function automatic logic [DATA_W-1:0] reg_value(reg_idx_t idx);
		case (idx)
			REG_ZERO_LOW:   return DATA_W'(zero_low_q);
			REG_ZERO_HIGH:  return DATA_W'(zero_high_q);
			REG_ONE_LOW:    return DATA_W'(one_low_q);
			REG_ONE_HIGH:   return DATA_W'(one_high_q);
			REG_WIN_FIRST:  return DATA_W'(win_first_q);
			REG_WIN_STOP:   return DATA_W'(win_stop_q);
			REG_SIRC_SHIFT: return DATA_W'(sirc_shift_q);
			default:        return '0;
		endcase
	endfunction

	// output checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (cmd_expected_q.size() == 0) begin
				$display("%0t ERROR unexpected command_byte transfer: expected none, actual %02h",
					$time, command_byte);
				mismatch_cnt++;
			end else begin
				cmd_head = cmd_expected_q.pop_front();
				if (command_byte !== cmd_head) begin
					$display("%0t ERROR command_byte expected %02h actual %02h",
						$time, cmd_head, command_byte);
					mismatch_cnt++;
				end
			end
		end
	end

	// downstream ready: random modes, plus a long hold on request
	always @(posedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_ready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_cnt = HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_mode_left = $urandom_range(50, 300);
			end
			rx_mode_left--;
			case (rx_mode)
				RX_ALWAYS: out_ready <= 1'b1;
				RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
				RX_SLOW:   out_ready <= ($urandom_range(0, 3) == 0);
				default:   out_ready <= rx_mode_left[2];
			endcase
		end
	end

	task automatic apb_access(bit wr, reg_idx_t idx, logic [DATA_W-1:0] wdata,
			output logic [DATA_W-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_reg(reg_idx_t idx);
		logic [DATA_W-1:0] rd;
		apb_access(1'b0, idx, '0, rd);
		if (rd !== reg_value(idx)) begin
			$display("%0t ERROR register %s expected %0h actual %0h",
				$time, idx.name(), reg_value(idx), rd);
			mismatch_cnt++;
		end
	endtask

	task automatic write_reg(reg_idx_t idx, int value);
		logic [DATA_W-1:0] rd;
		case (idx)
			REG_ZERO_LOW:   zero_low_q = value[BAND_W-1:0];
			REG_ZERO_HIGH:  zero_high_q = value[BAND_W-1:0];
			REG_ONE_LOW:    one_low_q = value[BAND_W-1:0];
			REG_ONE_HIGH:   one_high_q = value[BAND_W-1:0];
			REG_WIN_FIRST:  win_first_q = value[WIN_W-1:0];
			REG_WIN_STOP:   win_stop_q = value[WIN_W-1:0];
			REG_SIRC_SHIFT: sirc_shift_q = value[0];
			default: ;
		endcase
		apb_access(1'b1, idx, reg_value(idx), rd);
		check_reg(idx);
	endtask

	task automatic set_config(int zl, int zh, int ol, int oh, int wf, int ws, int sirc);
		write_reg(REG_ZERO_LOW, zl);
		write_reg(REG_ZERO_HIGH, zh);
		write_reg(REG_ONE_LOW, ol);
		write_reg(REG_ONE_HIGH, oh);
		write_reg(REG_WIN_FIRST, wf);
		write_reg(REG_WIN_STOP, ws);
		write_reg(REG_SIRC_SHIFT, sirc);
	endtask

	// offer one symbol, hold it until the transfer, then predict
	task automatic send_symbol(int d0, int d1, bit last);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gaps_on)
				gap = $urandom_range(1, 8);
		end
		burst_left--;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		first_duration <= d0[DUR_W-1:0];
		second_duration <= d1[DUR_W-1:0];
		frame_end <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		decode_symbol(d0[DUR_W-1:0], d1[DUR_W-1:0], last);
		items_sent++;
	endtask

	// drop valid, wait for every queued byte, then let the pipeline settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (cmd_expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// pick a symbol: mostly inside a band, some on the edges, some noise
	task automatic pick_durations(output int d0, output int d1);
		int kind;
		int lo;
		int hi;
		int sum;
		kind = $urandom_range(0, 9);
		lo = 0;
		hi = 0;
		if (kind == 9) begin
			d0 = $urandom_range(0, DUR_MAX);
			d1 = $urandom_range(0, DUR_MAX);
		end else begin
			if (kind <= 3) begin
				lo = int'(zero_low_q);
				hi = int'(zero_high_q);
			end else if (kind <= 6) begin
				lo = int'(one_low_q);
				hi = int'(one_high_q);
			end
			if (kind <= 6) begin
				sum = (hi > lo + 1) ? $urandom_range(lo + 1, hi - 1) : $urandom_range(0, SUM_MAX);
			end else if (kind == 7) begin
				case ($urandom_range(0, 3))
					0:       sum = int'(zero_low_q);
					1:       sum = int'(zero_high_q);
					2:       sum = int'(one_low_q);
					default: sum = int'(one_high_q);
				endcase
				sum = sum + $urandom_range(0, 2) - 1;
			end else begin
				sum = $urandom_range(0, SUM_MAX);
			end
			if (sum < 0)
				sum = 0;
			if (sum > SUM_MAX)
				sum = SUM_MAX;
			d0 = $urandom_range((sum > DUR_MAX) ? sum - DUR_MAX : 0,
				(sum < DUR_MAX) ? sum : DUR_MAX);
			d1 = sum - d0;
		end
	endtask

	task automatic send_frame(int len);
		int d0;
		int d1;
		for (int i = 0; i < len; i++) begin
			pick_durations(d0, d1);
			send_symbol(d0, d1, i == len - 1);
		end
	endtask

	task automatic test_reset_values();
		for (int i = 0; i <= int'(REG_SIRC_SHIFT); i++)
			check_reg(reg_idx_t'(i));
	endtask

	// sums just inside and exactly on every band edge, then the sum extremes
	task automatic test_band_edges();
		set_config(1050, 1250, 2100, 2400, 0, 8, 0);
		send_symbol(1051, 0, 1'b0);
		send_symbol(1200, 1199, 1'b0);
		send_symbol(0, 1249, 1'b0);
		send_symbol(2000, 101, 1'b0);
		send_symbol(525, 525, 1'b0);
		send_symbol(625, 625, 1'b0);
		send_symbol(2100, 0, 1'b0);
		send_symbol(1200, 1200, 1'b1);
		send_symbol(0, 0, 1'b1);
		send_symbol(DUR_MAX, DUR_MAX, 1'b1);
		wait_idle();
	endtask

	// a sum inside both bands must count as zero; SIRC shift on the result
	task automatic test_band_overlap_sirc();
		set_config(1000, 2200, 2000, 2500, 0, 64, 1);
		send_symbol(1050, 1050, 1'b0);
		send_symbol(1150, 1150, 1'b0);
		send_symbol(2299, 1, 1'b0);
		send_symbol(0, 2300, 1'b1);
		wait_idle();
	endtask

	// empty window, frame shorter than the window, window past the saturation
	task automatic test_window_edges();
		set_config(0, 65535, 65535, 0, 127, 0, 0);
		send_symbol(1, 0, 1'b0);
		send_symbol(DUR_MAX, DUR_MAX, 1'b0);
		send_symbol(100, 100, 1'b0);
		send_symbol(5, 5, 1'b1);
		wait_idle();
		set_config(0, 1000, 1000, 65535, 0, 127, 0);
		send_symbol(1000, 1000, 1'b0);
		send_symbol(250, 250, 1'b0);
		send_symbol(0, 2000, 1'b1);
		wait_idle();
		write_reg(REG_WIN_FIRST, 64);
		for (int i = 0; i < 70; i++)
			send_symbol(2000, 2000, i == 69);
		wait_idle();
	endtask

	task automatic test_random_traffic();
		int phase_end;
		int zl;
		int zh;
		int ol;
		int oh;
		int wf;
		int ws;
		int r;
		int len;
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: set_config(1050, 1250, 2100, 2400, 17, 25, 0);
				1: set_config(1050, 1350, 1650, 1950, 1, 13, 1);
				2: set_config(0, 65535, 0, 65535, 0, 127, 0);
				3: set_config(1050, 1250, 2100, 2400, 56, 127, 1);
				default: begin
					zl = $urandom_range(0, 40000);
					zh = zl + $urandom_range(0, 3000);
					ol = $urandom_range(0, 60000);
					oh = ol + $urandom_range(0, 5000);
					if (oh > 65535)
						oh = 65535;
					wf = $urandom_range(0, 20);
					ws = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
						: wf + $urandom_range(0, 12);
					set_config(zl, zh, ol, oh, wf, ws, $urandom_range(0, 1));
				end
			endcase
			gaps_on = ($urandom_range(0, 3) != 0);
			phase_end = items_sent + NUM_ITEMS / NUM_PHASES;
			while (items_sent < phase_end) begin
				r = $urandom_range(0, 9);
				if (r < 7)
					len = (win_stop_q >= 1 && win_stop_q <= 40)
						? int'(win_stop_q) + $urandom_range(0, 3) : $urandom_range(1, 40);
				else if (r < 9)
					len = $urandom_range(1, 12);
				else
					len = $urandom_range(60, 90);
				send_frame(len);
			end
			wait_idle();
		end
		gaps_on = 1'b1;
	endtask

	// hold the output long enough that frame ends back up into the input
	task automatic test_backpressure();
		set_config(1050, 1250, 2100, 2400, 0, 3, 0);
		gaps_on = 1'b0;
		hold_req = 1'b1;
		for (int i = 0; i < 30; i++)
			send_frame($urandom_range(1, 3));
		gaps_on = 1'b1;
		wait_idle();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_band_edges();
		test_band_overlap_sirc();
		test_window_edges();
		test_random_traffic();
		test_backpressure();
		if (mismatch_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
